FILE: hw/rtl/binary_max_heap_queue_macros.svh
// Assertion macros for the heap priority queue RTL.
`ifndef BINARY_MAX_HEAP_QUEUE_MACROS_SVH
`define BINARY_MAX_HEAP_QUEUE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define BMHQ_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("bmhq assertion failed");
`define BMHQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bmhq assertion failed");
`else
`define BMHQ_ASSERT(lbl, clk, rst_n, prop)
`define BMHQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: hw/rtl/bmhq_pkg.sv
// Shared types and codes of the heap priority queue.
package bmhq_pkg;

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_POP    = 1'b1;

	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_POPPED   = 2'd1,
		ST_FULL     = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	typedef struct packed {
		logic    valid;
		status_t status;
		logic    empty;
	} res_ctl_t;

endpackage

FILE: hw/rtl/bmhq_ram.sv
// Generic single-write, dual-read synchronous RAM with registered read data.
module bmhq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] ra_addr,
	input  logic [$clog2(DEPTH)-1:0] rb_addr,
	output logic [WIDTH-1:0]         ra_data,
	output logic [WIDTH-1:0]         rb_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		ra_data <= mem[ra_addr];
		rb_data <= mem[rb_addr];
	end

endmodule

FILE: hw/rtl/bmhq_ctrl.sv
// Heap sequencer: insert sift-up and pop sift-down over the heap RAM.
`include "binary_max_heap_queue_macros.svh"
module bmhq_ctrl #(
	parameter int CAPACITY  = 256,
	parameter int PRIO_BITS = 16,
	parameter int TAG_BITS  = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            kind,
	input  logic [PRIO_BITS-1:0]            new_priority,
	input  logic [TAG_BITS-1:0]             new_tag,
	output logic                            we,
	output logic [$clog2(CAPACITY)-1:0]     waddr,
	output logic [PRIO_BITS+TAG_BITS-1:0]   wdata,
	output logic [$clog2(CAPACITY)-1:0]     ra_addr,
	output logic [$clog2(CAPACITY)-1:0]     rb_addr,
	input  logic [PRIO_BITS+TAG_BITS-1:0]   ra_data,
	input  logic [PRIO_BITS+TAG_BITS-1:0]   rb_data,
	output bmhq_pkg::res_ctl_t              res,
	input  logic                            res_ready,
	output logic [PRIO_BITS-1:0]            res_priority,
	output logic [TAG_BITS-1:0]             res_tag,
	output logic [$clog2(CAPACITY+1)-1:0]   res_count
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = AW + 2;
	localparam int EW = PRIO_BITS + TAG_BITS;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_UP   = 6'b000010,
		S_POP  = 6'b000100,
		S_DOWN = 6'b001000,
		S_PUT  = 6'b010000,
		S_FIN  = 6'b100000
	} state_t;

	state_t              state_q, state_d;
	logic [CW-1:0]       count_q, count_d;
	logic [AW-1:0]       idx_q, idx_d;
	logic [EW-1:0]       mov_q, mov_d;
	logic [EW-1:0]       pop_q, pop_d;
	bmhq_pkg::status_t   status_q, status_d;

	logic [AW-1:0]       ins_par, cur_par, next_par, cnt_m1, child;
	logic [XW-1:0]       lx, rx, cnt_x, ncl;
	logic                pick_l, pick_r;
	logic [PRIO_BITS-1:0] best_prio;
	logic [EW-1:0]       centry;

	assign ins_par  = (count_q[AW-1:0] - 1'b1) >> 1;
	assign cur_par  = (idx_q - 1'b1) >> 1;
	assign next_par = (cur_par - 1'b1) >> 1;
	assign cnt_m1   = AW'(count_q - 1'b1);

	assign lx     = {1'b0, idx_q, 1'b1};
	assign rx     = lx + 1'b1;
	assign cnt_x  = XW'(count_q);
	assign pick_l = mov_q[EW-1 -: PRIO_BITS] < ra_data[EW-1 -: PRIO_BITS];
	assign best_prio = pick_l ? ra_data[EW-1 -: PRIO_BITS] : mov_q[EW-1 -: PRIO_BITS];
	assign pick_r = (rx < cnt_x) && (best_prio < rb_data[EW-1 -: PRIO_BITS]);
	assign child  = pick_r ? rx[AW-1:0] : lx[AW-1:0];
	assign centry = pick_r ? rb_data : ra_data;
	assign ncl    = {1'b0, child, 1'b1};

	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		idx_d    = idx_q;
		mov_d    = mov_q;
		pop_d    = pop_q;
		status_d = status_q;
		we       = 1'b0;
		waddr    = idx_q;
		wdata    = mov_q;
		ra_addr  = '0;
		rb_addr  = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					pop_d = '0;
					if (kind == bmhq_pkg::KIND_INSERT) begin
						if (count_q == CW'(CAPACITY)) begin
							status_d = bmhq_pkg::ST_FULL;
							state_d  = S_FIN;
						end else begin
							status_d = bmhq_pkg::ST_INSERTED;
							mov_d    = {new_priority, new_tag};
							idx_d    = count_q[AW-1:0];
							count_d  = count_q + 1'b1;
							if (count_q == '0) begin
								we      = 1'b1;
								waddr   = '0;
								wdata   = {new_priority, new_tag};
								state_d = S_FIN;
							end else begin
								ra_addr = ins_par;
								state_d = S_UP;
							end
						end
					end else begin
						if (count_q == '0) begin
							status_d = bmhq_pkg::ST_EMPTY;
							state_d  = S_FIN;
						end else begin
							status_d = bmhq_pkg::ST_POPPED;
							ra_addr  = '0;
							rb_addr  = cnt_m1;
							count_d  = count_q - 1'b1;
							state_d  = S_POP;
						end
					end
				end
			end
			S_UP: begin
				we = 1'b1;
				if (mov_q[EW-1 -: PRIO_BITS] > ra_data[EW-1 -: PRIO_BITS]) begin
					wdata = ra_data;
					idx_d = cur_par;
					if (cur_par == '0) begin
						state_d = S_PUT;
					end else begin
						ra_addr = next_par;
					end
				end else begin
					state_d = S_FIN;
				end
			end
			S_POP: begin
				pop_d = ra_data;
				mov_d = rb_data;
				idx_d = '0;
				if (count_q == '0) begin
					state_d = S_FIN;
				end else if (count_q == CW'(1)) begin
					we      = 1'b1;
					waddr   = '0;
					wdata   = rb_data;
					state_d = S_FIN;
				end else begin
					ra_addr = AW'(1);
					rb_addr = AW'(2);
					state_d = S_DOWN;
				end
			end
			S_DOWN: begin
				we = 1'b1;
				if (pick_l || pick_r) begin
					wdata = centry;
					idx_d = child;
					if (ncl < cnt_x) begin
						ra_addr = ncl[AW-1:0];
						rb_addr = ncl[AW-1:0] + 1'b1;
					end else begin
						state_d = S_PUT;
					end
				end else begin
					state_d = S_FIN;
				end
			end
			S_PUT: begin
				we      = 1'b1;
				state_d = S_FIN;
			end
			S_FIN: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q    <= idx_d;
		mov_q    <= mov_d;
		pop_q    <= pop_d;
		status_q <= status_d;
	end

	assign in_ready     = (state_q == S_IDLE);
	assign res.valid    = (state_q == S_FIN);
	assign res.status   = status_q;
	assign res.empty    = (count_q == '0);
	assign res_priority = pop_q[EW-1 -: PRIO_BITS];
	assign res_tag      = pop_q[TAG_BITS-1:0];
	assign res_count    = count_q;

	`BMHQ_ASSERT(a_count_bound, clk, arst_n, count_q <= CW'(CAPACITY))
	`BMHQ_ASSERT(a_up_not_root, clk, arst_n, (state_q == S_UP) |-> (idx_q != '0))
	`BMHQ_ASSERT(a_write_in_heap, clk, arst_n, (we && state_q != S_IDLE) |-> (XW'(waddr) < cnt_x))
	`BMHQ_ASSERT_NEXT(a_pop_count, clk, arst_n, in_valid && in_ready && kind == bmhq_pkg::KIND_POP && count_q != '0, count_q == $past(count_q) - 1'b1)

endmodule

FILE: hw/rtl/binary_max_heap_queue.sv
// Max-priority queue on a binary heap in one RAM; sift-up/sift-down handles one level per cycle.
// Full rejects, empty pops and inserts into an empty heap finish without a sift; an insert or pop
// may walk the whole height of the heap. One item is in flight at a time; the next input word
// is taken the cycle after the result loads the output register.
// Reset clears the entry count and control; heap RAM contents are left as they are.
module binary_max_heap_queue #(
	parameter int CAPACITY  = 256,
	parameter int PRIO_BITS = 16,
	parameter int TAG_BITS  = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          kind,
	input  logic [PRIO_BITS-1:0]          new_priority,
	input  logic [TAG_BITS-1:0]           new_tag,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    status,
	output logic [PRIO_BITS-1:0]          out_priority,
	output logic [TAG_BITS-1:0]           out_tag,
	output logic [$clog2(CAPACITY+1)-1:0] entry_total,
	output logic                          is_empty
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int EW = PRIO_BITS + TAG_BITS;

	logic                 we;
	logic [AW-1:0]        waddr, ra_addr, rb_addr;
	logic [EW-1:0]        wdata, ra_data, rb_data;
	bmhq_pkg::res_ctl_t   res;
	logic                 res_ready;
	logic [PRIO_BITS-1:0] res_priority;
	logic [TAG_BITS-1:0]  res_tag;
	logic [CW-1:0]        res_count;

	logic                 out_valid_q;
	logic [1:0]           status_q;
	logic [PRIO_BITS-1:0] out_priority_q;
	logic [TAG_BITS-1:0]  out_tag_q;
	logic [CW-1:0]        entry_total_q;
	logic                 is_empty_q;

	bmhq_ram #(
		.WIDTH(EW),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk    (clk),
		.we     (we),
		.waddr  (waddr),
		.wdata  (wdata),
		.ra_addr(ra_addr),
		.rb_addr(rb_addr),
		.ra_data(ra_data),
		.rb_data(rb_data)
	);

	bmhq_ctrl #(
		.CAPACITY (CAPACITY),
		.PRIO_BITS(PRIO_BITS),
		.TAG_BITS (TAG_BITS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.kind        (kind),
		.new_priority(new_priority),
		.new_tag     (new_tag),
		.we          (we),
		.waddr       (waddr),
		.wdata       (wdata),
		.ra_addr     (ra_addr),
		.rb_addr     (rb_addr),
		.ra_data     (ra_data),
		.rb_data     (rb_data),
		.res         (res),
		.res_ready   (res_ready),
		.res_priority(res_priority),
		.res_tag     (res_tag),
		.res_count   (res_count)
	);

	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid && res_ready) begin
			status_q       <= res.status;
			out_priority_q <= res_priority;
			out_tag_q      <= res_tag;
			entry_total_q  <= res_count;
			is_empty_q     <= res.empty;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign out_priority = out_priority_q;
	assign out_tag      = out_tag_q;
	assign entry_total  = entry_total_q;
	assign is_empty     = is_empty_q;

endmodule

FILE: verif/binary_max_heap_queue_tb.sv
`timescale 1ns / 100ps
// Testbench for the heap priority queue: predicts every output word and checks it field by field.
module binary_max_heap_queue_tb;

	localparam int CAPACITY  = 256;
	localparam int CYCLE_CAP = 400000;

	typedef struct packed {
		bmhq_pkg::status_t status;
		logic [15:0]       prio;
		logic [15:0]       tag;
		logic [8:0]        total;
		logic              empty;
	} heap_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        kind = bmhq_pkg::KIND_INSERT;
	logic [15:0] new_priority = '0;
	logic [15:0] new_tag = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  status;
	logic [15:0] out_priority;
	logic [15:0] out_tag;
	logic [8:0]  entry_total;
	logic        is_empty;

	logic [15:0]  slot_prio [CAPACITY];
	logic [15:0]  slot_tag [CAPACITY];
	int           held;
	heap_result_t pending_results [$];
	bit           steady;
	int           errors = 0;
	int           cycles = 0;
	int           sent;
	int           peak_fill;
	int           seen_inserted = 0;
	int           seen_popped = 0;
	int           seen_full = 0;
	int           seen_empty = 0;

	binary_max_heap_queue #(
		.CAPACITY(CAPACITY),
		.PRIO_BITS(16),
		.TAG_BITS(16)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.new_priority(new_priority),
		.new_tag(new_tag),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.out_priority(out_priority),
		.out_tag(out_tag),
		.entry_total(entry_total),
		.is_empty(is_empty)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("timeout after %0d cycles", cycles);
			$display("status: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_ready <= steady ? 1'b1 : ($urandom_range(99) >= 17);
	end

	function automatic void swap_slots(int a, int b);
		logic [15:0] p;
		logic [15:0] t;
		p = slot_prio[a];
		t = slot_tag[a];
		slot_prio[a] = slot_prio[b];
		slot_tag[a] = slot_tag[b];
		slot_prio[b] = p;
		slot_tag[b] = t;
	endfunction

	function automatic heap_result_t next_queue_result(logic op, logic [15:0] prio,
			logic [15:0] tag);
		heap_result_t r;
		int i, cl, cr, pick;
		bit done;
		r = '0;
		done = 1'b0;
		if (op == bmhq_pkg::KIND_INSERT) begin
			if (held >= CAPACITY) begin
				r.status = bmhq_pkg::ST_FULL;
			end else begin
				i = held;
				slot_prio[i] = prio;
				slot_tag[i] = tag;
				held++;
				while (i > 0 && !done) begin
					if (slot_prio[i] > slot_prio[(i - 1) / 2]) begin
						swap_slots(i, (i - 1) / 2);
						i = (i - 1) / 2;
					end else begin
						done = 1'b1;
					end
				end
				r.status = bmhq_pkg::ST_INSERTED;
			end
		end else if (held == 0) begin
			r.status = bmhq_pkg::ST_EMPTY;
		end else begin
			r.prio = slot_prio[0];
			r.tag = slot_tag[0];
			held--;
			slot_prio[0] = slot_prio[held];
			slot_tag[0] = slot_tag[held];
			i = 0;
			while (2 * i + 1 < held && !done) begin
				cl = 2 * i + 1;
				cr = 2 * i + 2;
				pick = i;
				if (slot_prio[i] < slot_prio[cl])
					pick = cl;
				if (cr < held && slot_prio[pick] < slot_prio[cr])
					pick = cr;
				if (pick == i) begin
					done = 1'b1;
				end else begin
					swap_slots(i, pick);
					i = pick;
				end
			end
			r.status = bmhq_pkg::ST_POPPED;
		end
		r.total = held[8:0];
		r.empty = (held == 0);
		return r;
	endfunction

	task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
		errors++;
		$display("mismatch %s at cycle %0d: got %0h want %0h", field, cycles, got, want);
	endtask

	always @(negedge clk) begin : check_word
		heap_result_t want;
		if (arst_n && out_valid && out_ready) begin
			case (status)
				bmhq_pkg::ST_INSERTED: seen_inserted++;
				bmhq_pkg::ST_POPPED:   seen_popped++;
				bmhq_pkg::ST_FULL:     seen_full++;
				default:               seen_empty++;
			endcase
			if (pending_results.size() == 0) begin
				report_mismatch("word with nothing pending", 32'(status), '0);
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status)
					report_mismatch("status", 32'(status), 32'(want.status));
				if (out_priority !== want.prio)
					report_mismatch("out_priority", 32'(out_priority), 32'(want.prio));
				if (out_tag !== want.tag)
					report_mismatch("out_tag", 32'(out_tag), 32'(want.tag));
				if (entry_total !== want.total)
					report_mismatch("entry_total", 32'(entry_total), 32'(want.total));
				if (is_empty !== want.empty)
					report_mismatch("is_empty", 32'(is_empty), 32'(want.empty));
			end
		end
	end

	task automatic send_word(logic op, logic [15:0] prio, logic [15:0] tag);
		bit taken;
		while (!steady && $urandom_range(99) < 17) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= op;
		new_priority <= prio;
		new_tag <= tag;
		do begin
			@(negedge clk);
			taken = in_ready;
			@(posedge clk);
		end while (!taken);
		pending_results.push_back(next_queue_result(op, prio, tag));
		sent++;
		if (held > peak_fill)
			peak_fill = held;
	endtask

	task automatic hold_input();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain_results();
		hold_input();
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_empty_pop();
		send_word(bmhq_pkg::KIND_POP, 16'h0000, 16'h0000);
		send_word(bmhq_pkg::KIND_INSERT, 16'hffff, 16'hffff);
		send_word(bmhq_pkg::KIND_POP, 16'hffff, 16'hffff);
		send_word(bmhq_pkg::KIND_POP, 16'h1234, 16'h5678);
	endtask

	task automatic test_extremes_and_ties();
		send_word(bmhq_pkg::KIND_INSERT, 16'h0000, 16'h0000);
		send_word(bmhq_pkg::KIND_INSERT, 16'hffff, 16'hffff);
		send_word(bmhq_pkg::KIND_INSERT, 16'h8000, 16'h5555);
		send_word(bmhq_pkg::KIND_INSERT, 16'h7fff, 16'haaaa);
		send_word(bmhq_pkg::KIND_INSERT, 16'h1234, 16'h0001);
		send_word(bmhq_pkg::KIND_INSERT, 16'h1234, 16'h0002);
		send_word(bmhq_pkg::KIND_INSERT, 16'h1234, 16'h0003);
		send_word(bmhq_pkg::KIND_INSERT, 16'hffff, 16'h0f0f);
		repeat (9)
			send_word(bmhq_pkg::KIND_POP, 16'h0000, 16'h0000);
	endtask

	task automatic test_fill_to_capacity();
		steady = 1'b1;
		repeat (CAPACITY)
			send_word(bmhq_pkg::KIND_INSERT, 16'($urandom_range(0, 63)),
				16'($urandom_range(0, 65535)));
		send_word(bmhq_pkg::KIND_INSERT, 16'hffff, 16'hffff);
		send_word(bmhq_pkg::KIND_INSERT, 16'h0000, 16'h0000);
		send_word(bmhq_pkg::KIND_POP, 16'h0000, 16'h0000);
		send_word(bmhq_pkg::KIND_INSERT, 16'hffff, 16'h00ff);
		steady = 1'b0;
		drain_results();
		repeat (CAPACITY + 1)
			send_word(bmhq_pkg::KIND_POP, 16'($urandom_range(0, 65535)),
				16'($urandom_range(0, 65535)));
	endtask

	task automatic test_random_mix();
		int insert_pct, span, mode, stop;
		logic [15:0] prio;
		stop = 1650;
		while (sent < stop) begin
			case ($urandom_range(4))
				0: insert_pct = 85;
				1: insert_pct = 15;
				2: insert_pct = 95;
				3: insert_pct = 5;
				default: insert_pct = 50;
			endcase
			mode = $urandom_range(2);
			span = $urandom_range(60, 220);
			repeat (span) begin
				if (sent < stop) begin
					case (mode)
						0: prio = 16'($urandom_range(0, 65535));
						1: prio = 16'($urandom_range(0, 7));
						default: prio = $urandom_range(1) ? 16'hffff : 16'h0000;
					endcase
					send_word(($urandom_range(99) < insert_pct) ?
						bmhq_pkg::KIND_INSERT : bmhq_pkg::KIND_POP,
						prio, 16'($urandom_range(0, 65535)));
				end
			end
			if ($urandom_range(3) == 0)
				drain_results();
		end
	endtask

	initial begin
		steady = 1'b0;
		sent = 0;
		held = 0;
		peak_fill = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_pop();
		test_extremes_and_ties();
		test_fill_to_capacity();
		test_random_mix();
		drain_results();
		repeat (24) @(posedge clk);
		$display("sent %0d words, peak fill %0d of %0d entries", sent, peak_fill, CAPACITY);
		$display("results: %0d inserted, %0d popped, %0d full rejects, %0d empty pops",
			seen_inserted, seen_popped, seen_full, seen_empty);
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches", errors);
			$display("status: fail");
		end
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/bmhq_pkg.sv
hw/rtl/bmhq_ram.sv
hw/rtl/bmhq_ctrl.sv
hw/rtl/binary_max_heap_queue.sv
verif/binary_max_heap_queue_tb.sv
